### src/mfu_pkg.sv
package mfu_pkg;

  localparam int MOTORS_DEFAULT      = 4;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int ID_W      = 11;
  localparam int THR_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [ID_W-1:0]  ID_BASE_RESET = 11'd513;
  localparam logic [THR_W-1:0] THR_RESET     = 13'd4095;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ID_BASE  = 2'd0,
    REG_JUMP_THR = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] speed;
    logic [15:0] torque;
  } frame_t;

  localparam int TURNS_W = 24;
  localparam logic signed [TURNS_W-1:0] TURNS_MAX = 24'sh7FFFFF;
  localparam logic signed [TURNS_W-1:0] TURNS_MIN = 24'sh800000;

  localparam int TOTAL_W  = 37;
  localparam int SANGLE_W = 36;
  localparam int SSPEED_W = 19;

  // shaft speed: floor(s * 64 / 9), numerator biased positive
  localparam int SPD_NUM_W   = 23;
  localparam int SPD_RECIP_W = 24;
  localparam int SPD_PROD_W  = SPD_NUM_W + SPD_RECIP_W;
  localparam int SPD_SHIFT   = 27;
  localparam int SPD_DIV     = 9;
  localparam int SPD_OFS_LOG = 18;
  localparam logic [SPD_NUM_W-1:0] SPD_BIAS = 23'(SPD_DIV * (1 << SPD_OFS_LOG));
  localparam logic [SPD_RECIP_W-1:0] SPD_RECIP =
    24'(((64'd1 << SPD_SHIFT) + 64'(SPD_DIV) - 64'd1) / 64'(SPD_DIV));

  // shaft angle fraction: floor(d * 2560 / 8191), numerator biased positive
  localparam int ANG_NUM_W   = 29;
  localparam int ANG_RECIP_W = 30;
  localparam int ANG_PROD_W  = ANG_NUM_W + ANG_RECIP_W;
  localparam int ANG_SHIFT   = 42;
  localparam int ANG_DIV     = 8191;
  localparam int ANG_OFS_LOG = 15;
  localparam logic [ANG_NUM_W-1:0] ANG_BIAS = 29'(ANG_DIV * (1 << ANG_OFS_LOG));
  localparam logic [ANG_RECIP_W-1:0] ANG_RECIP =
    30'(((64'd1 << ANG_SHIFT) + 64'(ANG_DIV) - 64'd1) / 64'(ANG_DIV));

endpackage

### src/motor_feedback_unwrap.sv
// a request taken from the queue passes the update, multiply and final steps of the
// four-step back-end sequencer into the result register, waiting for a free output;
// no new request is taken until the last one is in the result register
// requests whose identifier lies outside the motor range give no result
// reset: registers take their reset values, every motor is marked unseen,
// queue and result register empty; no clearing pass
module motor_feedback_unwrap #(
  parameter int MOTORS      = mfu_pkg::MOTORS_DEFAULT,
  parameter int QUEUE_DEPTH = mfu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfu_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mfu_pkg::ID_W-1:0]            in_frame_id,
  input  logic [7:0]                          in_angle_high,
  input  logic [7:0]                          in_angle_low,
  input  logic [7:0]                          in_speed_high,
  input  logic [7:0]                          in_speed_low,
  input  logic [7:0]                          in_torque_high,
  input  logic [7:0]                          in_torque_low,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_motor_index,
  output logic [15:0]                         out_rotor_angle,
  output logic signed [15:0]                  out_rotor_speed,
  output logic signed [15:0]                  out_torque_current,
  output logic signed [mfu_pkg::SSPEED_W-1:0] out_shaft_speed_q8,
  output logic signed [mfu_pkg::TURNS_W-1:0]  out_turn_count,
  output logic signed [mfu_pkg::TOTAL_W-1:0]  out_rotor_counts_total,
  output logic signed [mfu_pkg::SANGLE_W-1:0] out_shaft_angle_q8
);

  localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
  localparam int QW = IW + $bits(mfu_pkg::frame_t);

  logic [mfu_pkg::ID_W-1:0]  id_base_r;
  logic [mfu_pkg::THR_W-1:0] jump_thr_r;

  logic                      push_valid;
  logic                      push_ready;
  logic [IW-1:0]             push_idx;
  mfu_pkg::frame_t           push_frame;
  logic                      pop_valid;
  logic                      pop_ready;
  logic [QW-1:0]             pop_data;
  logic [IW-1:0]             pop_idx;
  mfu_pkg::frame_t           pop_frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_base_r  <= mfu_pkg::ID_BASE_RESET;
      jump_thr_r <= mfu_pkg::THR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mfu_pkg::REG_ID_BASE:  id_base_r  <= cfg_wdata[mfu_pkg::ID_W-1:0];
        mfu_pkg::REG_JUMP_THR: jump_thr_r <= cfg_wdata[mfu_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  mfu_front #(.MOTORS(MOTORS)) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_frame_id    (in_frame_id),
    .in_angle_high  (in_angle_high),
    .in_angle_low   (in_angle_low),
    .in_speed_high  (in_speed_high),
    .in_speed_low   (in_speed_low),
    .in_torque_high (in_torque_high),
    .in_torque_low  (in_torque_low),
    .id_base        (id_base_r),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_idx       (push_idx),
    .push_frame     (push_frame)
  );

  mfu_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_idx, push_frame}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_idx   = pop_data[QW-1:$bits(mfu_pkg::frame_t)];
  assign pop_frame = pop_data[$bits(mfu_pkg::frame_t)-1:0];

  mfu_back #(.MOTORS(MOTORS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .jump_threshold         (jump_thr_r),
    .q_valid                (pop_valid),
    .q_ready                (pop_ready),
    .q_idx                  (pop_idx),
    .q_frame                (pop_frame),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_motor_index        (out_motor_index),
    .out_rotor_angle        (out_rotor_angle),
    .out_rotor_speed        (out_rotor_speed),
    .out_torque_current     (out_torque_current),
    .out_shaft_speed_q8     (out_shaft_speed_q8),
    .out_turn_count         (out_turn_count),
    .out_rotor_counts_total (out_rotor_counts_total),
    .out_shaft_angle_q8     (out_shaft_angle_q8)
  );

endmodule

### src/mfu_front.sv
module mfu_front #(
  parameter int MOTORS = mfu_pkg::MOTORS_DEFAULT
) (
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mfu_pkg::ID_W-1:0]        in_frame_id,
  input  logic [7:0]                      in_angle_high,
  input  logic [7:0]                      in_angle_low,
  input  logic [7:0]                      in_speed_high,
  input  logic [7:0]                      in_speed_low,
  input  logic [7:0]                      in_torque_high,
  input  logic [7:0]                      in_torque_low,
  input  logic [mfu_pkg::ID_W-1:0]        id_base,
  output logic                            push_valid,
  input  logic                            push_ready,
  output logic [((MOTORS > 1) ? $clog2(MOTORS) : 1)-1:0] push_idx,
  output mfu_pkg::frame_t                 push_frame
);

  localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  logic [mfu_pkg::ID_W:0] diff;
  logic                   hit;

  assign diff = {1'b0, in_frame_id} - {1'b0, id_base};
  assign hit  = !diff[mfu_pkg::ID_W] && (diff < (mfu_pkg::ID_W + 1)'(MOTORS));

  assign in_ready   = push_ready;
  assign push_valid = in_valid && hit;
  assign push_idx   = IW'(diff);

  assign push_frame.angle  = {in_angle_high, in_angle_low};
  assign push_frame.speed  = {in_speed_high, in_speed_low};
  assign push_frame.torque = {in_torque_high, in_torque_low};

endmodule

### src/mfu_queue.sv
module mfu_queue #(
  parameter int W     = 8,
  parameter int DEPTH = mfu_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_fire) begin
        mem_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count_r <= count_r + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r == rd_ptr_r) |-> (count_r == '0 || count_r == CW'(DEPTH)))
    else $error("queue pointers disagree with fill count");

endmodule

### src/mfu_back.sv
module mfu_back #(
  parameter int MOTORS = mfu_pkg::MOTORS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [mfu_pkg::THR_W-1:0]               jump_threshold,
  input  logic                                    q_valid,
  output logic                                    q_ready,
  input  logic [((MOTORS > 1) ? $clog2(MOTORS) : 1)-1:0] q_idx,
  input  mfu_pkg::frame_t                         q_frame,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [1:0]                              out_motor_index,
  output logic [15:0]                             out_rotor_angle,
  output logic signed [15:0]                      out_rotor_speed,
  output logic signed [15:0]                      out_torque_current,
  output logic signed [mfu_pkg::SSPEED_W-1:0]     out_shaft_speed_q8,
  output logic signed [mfu_pkg::TURNS_W-1:0]      out_turn_count,
  output logic signed [mfu_pkg::TOTAL_W-1:0]      out_rotor_counts_total,
  output logic signed [mfu_pkg::SANGLE_W-1:0]     out_shaft_angle_q8
);

  localparam int IW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_MUL, S_FIN} state_t;

  state_t                                   state_r;
  logic [IW-1:0]                            idx_r;
  mfu_pkg::frame_t                          frame_r;

  logic [15:0]                              last_angle_r [MOTORS];
  logic [15:0]                              zero_offset_r [MOTORS];
  logic signed [mfu_pkg::TURNS_W-1:0]       turns_r [MOTORS];
  logic [MOTORS-1:0]                        seen_r;

  logic signed [mfu_pkg::TURNS_W-1:0]       turns_new_r;
  logic signed [16:0]                       diff_r;
  logic [mfu_pkg::SPD_NUM_W-1:0]            spd_num_r;
  logic [mfu_pkg::ANG_NUM_W-1:0]            ang_num_r;
  logic [mfu_pkg::SPD_PROD_W-1:0]           spd_prod_r;
  logic [mfu_pkg::ANG_PROD_W-1:0]           ang_prod_r;
  logic signed [mfu_pkg::TOTAL_W-1:0]       tprod_r;

  logic                                     out_valid_r;
  logic [1:0]                               out_idx_r;
  mfu_pkg::frame_t                          out_frame_r;
  logic signed [mfu_pkg::SSPEED_W-1:0]      out_sspeed_r;
  logic signed [mfu_pkg::TURNS_W-1:0]       out_turns_r;
  logic signed [mfu_pkg::TOTAL_W-1:0]       out_total_r;
  logic signed [mfu_pkg::SANGLE_W-1:0]      out_sangle_r;

  logic                                     seen_c;
  logic [15:0]                              last_eff;
  logic [15:0]                              off_eff;
  logic signed [mfu_pkg::TURNS_W-1:0]       t_eff;
  logic signed [16:0]                       delta;
  logic signed [16:0]                       thr_s;
  logic signed [mfu_pkg::TURNS_W-1:0]       turns_nxt;
  logic signed [16:0]                       diff_nxt;
  logic signed [mfu_pkg::ANG_NUM_W-1:0]     diff_x;
  logic signed [mfu_pkg::SPD_NUM_W-1:0]     spd_x;
  logic [mfu_pkg::ANG_NUM_W-1:0]            ang_num_nxt;
  logic [mfu_pkg::SPD_NUM_W-1:0]            spd_num_nxt;
  logic [mfu_pkg::SPD_PROD_W-mfu_pkg::SPD_SHIFT-1:0] spd_q;
  logic [mfu_pkg::ANG_PROD_W-mfu_pkg::ANG_SHIFT-1:0] ang_q;
  logic signed [mfu_pkg::ANG_PROD_W-mfu_pkg::ANG_SHIFT-1:0] ang_frac;
  logic signed [mfu_pkg::SANGLE_W-1:0]      t36;
  logic signed [mfu_pkg::SSPEED_W-1:0]      sspeed_nxt;
  logic signed [mfu_pkg::SANGLE_W-1:0]      sangle_nxt;
  logic signed [mfu_pkg::TOTAL_W-1:0]       total_nxt;
  logic                                     out_free;

  // first frame of a motor: offset and last angle take the new angle
  assign seen_c   = seen_r[idx_r];
  assign last_eff = seen_c ? last_angle_r[idx_r] : frame_r.angle;
  assign off_eff  = seen_c ? zero_offset_r[idx_r] : frame_r.angle;
  assign t_eff    = seen_c ? turns_r[idx_r] : '0;

  assign delta = $signed({1'b0, frame_r.angle}) - $signed({1'b0, last_eff});
  assign thr_s = $signed({4'b0, jump_threshold});

  always_comb begin
    turns_nxt = t_eff;
    if (delta > thr_s) begin
      if (t_eff != mfu_pkg::TURNS_MIN) turns_nxt = t_eff - 1'b1;
    end else if (delta < -thr_s) begin
      if (t_eff != mfu_pkg::TURNS_MAX) turns_nxt = t_eff + 1'b1;
    end
  end

  assign diff_nxt    = $signed({1'b0, frame_r.angle}) - $signed({1'b0, off_eff});
  assign diff_x      = mfu_pkg::ANG_NUM_W'(diff_nxt);
  assign ang_num_nxt = $unsigned(diff_x <<< 11) + $unsigned(diff_x <<< 9) + mfu_pkg::ANG_BIAS;
  assign spd_x       = mfu_pkg::SPD_NUM_W'($signed(frame_r.speed));
  assign spd_num_nxt = $unsigned(spd_x <<< 6) + mfu_pkg::SPD_BIAS;

  // remove the biases after the reciprocal multiplies
  assign spd_q      = spd_prod_r[mfu_pkg::SPD_PROD_W-1:mfu_pkg::SPD_SHIFT];
  assign ang_q      = ang_prod_r[mfu_pkg::ANG_PROD_W-1:mfu_pkg::ANG_SHIFT];
  assign sspeed_nxt = $signed(mfu_pkg::SSPEED_W'(spd_q - ($bits(spd_q))'(1 << mfu_pkg::SPD_OFS_LOG)));
  assign ang_frac   = $signed(ang_q - ($bits(ang_q))'(1 << mfu_pkg::ANG_OFS_LOG));
  assign t36        = mfu_pkg::SANGLE_W'(turns_new_r);
  assign sangle_nxt = (t36 <<< 11) + (t36 <<< 9) + mfu_pkg::SANGLE_W'(ang_frac);
  assign total_nxt  = tprod_r + mfu_pkg::TOTAL_W'(diff_r);

  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            idx_r   <= q_idx;
            frame_r <= q_frame;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          last_angle_r[idx_r]  <= frame_r.angle;
          zero_offset_r[idx_r] <= off_eff;
          turns_r[idx_r]       <= turns_nxt;
          seen_r[idx_r]        <= 1'b1;
          turns_new_r          <= turns_nxt;
          diff_r               <= diff_nxt;
          ang_num_r            <= ang_num_nxt;
          spd_num_r            <= spd_num_nxt;
          state_r              <= S_MUL;
        end
        S_MUL: begin
          spd_prod_r <= mfu_pkg::SPD_PROD_W'(spd_num_r) * mfu_pkg::SPD_PROD_W'(mfu_pkg::SPD_RECIP);
          ang_prod_r <= mfu_pkg::ANG_PROD_W'(ang_num_r) * mfu_pkg::ANG_PROD_W'(mfu_pkg::ANG_RECIP);
          tprod_r    <= (mfu_pkg::TOTAL_W'(turns_new_r) <<< 13) - mfu_pkg::TOTAL_W'(turns_new_r);
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_idx_r    <= 2'(idx_r);
            out_frame_r  <= frame_r;
            out_sspeed_r <= sspeed_nxt;
            out_turns_r  <= turns_new_r;
            out_total_r  <= total_nxt;
            out_sangle_r <= sangle_nxt;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid              = out_valid_r;
  assign out_motor_index        = out_idx_r;
  assign out_rotor_angle        = out_frame_r.angle;
  assign out_rotor_speed        = $signed(out_frame_r.speed);
  assign out_torque_current     = $signed(out_frame_r.torque);
  assign out_shaft_speed_q8     = out_sspeed_r;
  assign out_turn_count         = out_turns_r;
  assign out_rotor_counts_total = out_total_r;
  assign out_shaft_angle_q8     = out_sangle_r;

  a_turn_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> (turns_nxt == t_eff || turns_nxt == t_eff + 1'b1 ||
                            turns_nxt == t_eff - 1'b1))
    else $error("turn counter moved by more than one");

  a_first_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD && !seen_c) |=>
      (seen_r[idx_r] && zero_offset_r[idx_r] == frame_r.angle && turns_r[idx_r] == turns_new_r))
    else $error("first frame did not set up motor state");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the final step");

endmodule
